// ===== sv/tcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Text card port decoder package
// Widths, port codes, register indexes and shared types of the text card.
// ----------------------------------------------------------------------------
package tcpd_pkg;

   localparam int RAM_SIZE_DEF  = 2048;
   localparam int REG_COUNT_DEF = 18;

   localparam int DATA_W     = 8;
   localparam int PORT_W     = 16;
   localparam int CMD_W      = 2;
   localparam int CNT_W      = 8;
   localparam int PHASE_W    = 12;
   localparam int SUM_W      = PHASE_W + 1;
   localparam int STEP_W     = 4;
   localparam int SEL_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK   = 2'd2;

   localparam logic [DATA_W-1:0] PORT_RAM_MASK = 8'hf8;
   localparam logic [DATA_W-1:0] PORT_RAM_BASE = 8'h40;
   localparam logic [DATA_W-1:0] PORT_SELECT   = 8'h48;
   localparam logic [DATA_W-1:0] PORT_DATA     = 8'h49;
   localparam logic [DATA_W-1:0] PORT_STATUS   = 8'h4c;

   localparam logic [DATA_W-1:0] STATUS_BASE  = 8'h02;
   localparam logic [DATA_W-1:0] STATUS_BLANK = 8'h01;
   localparam logic [DATA_W-1:0] FILL_BYTE    = 8'h20;
   localparam logic [DATA_W-1:0] NO_DATA      = 8'hff;

   localparam logic [PHASE_W-1:0] LINE_RESET  = 12'd256;
   localparam logic [PHASE_W-1:0] BLANK_RESET = 12'd64;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              port_hit;
   } tcpd_rsp_word_type;

   typedef struct packed {
      logic fast;
      logic done;
   } tcpd_phase_stat_type;

endpackage

// ===== sv/tcpd_ifs.sv =====
// ----------------------------------------------------------------------------
// Text card channel interfaces
// Valid/ready channels for bus words, result words and register writes.
// ----------------------------------------------------------------------------
interface tcpd_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcpd_pkg::CMD_W-1:0]    command;
   logic [tcpd_pkg::PORT_W-1:0]   port_address;
   logic [tcpd_pkg::DATA_W-1:0]   write_data;
   logic [tcpd_pkg::CNT_W-1:0]    tick_count;

   modport source (output valid, command, port_address, write_data, tick_count,
                   input ready);
   modport sink   (input valid, command, port_address, write_data, tick_count,
                   output ready);
endinterface

interface tcpd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcpd_pkg::DATA_W-1:0] read_data;
   logic                        port_hit;

   modport source (output valid, read_data, port_hit, input ready);
   modport sink   (input valid, read_data, port_hit, output ready);
endinterface

interface tcpd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tcpd_pkg::CSR_IDX_W-1:0]  index;
   logic [tcpd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tcpd_ram.sv =====
// ----------------------------------------------------------------------------
// Text card RAM
// Generic simple dual-port RAM with a registered read port that holds its data.
// ----------------------------------------------------------------------------
module tcpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tcpd_phase.sv =====
// ----------------------------------------------------------------------------
// Text card line phase unit
// Holds the scan-line phase and advances it modulo the line length, at once
// when at most one subtraction is needed and bit by bit otherwise.
// ----------------------------------------------------------------------------
module tcpd_phase (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tcpd_pkg::CNT_W-1:0]        tick_count,
   input  logic [tcpd_pkg::PHASE_W-1:0]      line_len,
   output logic [tcpd_pkg::PHASE_W-1:0]      phase,
   output tcpd_pkg::tcpd_phase_stat_type     stat
);

   logic [tcpd_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                         busy_ff, busy_in;
   logic [tcpd_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [tcpd_pkg::SUM_W-1:0]   num_ff, num_in;
   logic [tcpd_pkg::PHASE_W-1:0] rem_ff, rem_in;

   logic [tcpd_pkg::SUM_W-1:0]   sum;
   logic [tcpd_pkg::SUM_W-1:0]   line_ext;
   logic [tcpd_pkg::SUM_W-1:0]   diff;
   logic                         len_zero;
   logic                         sum_lt;
   logic                         diff_lt;
   logic                         fast;
   logic [tcpd_pkg::SUM_W-1:0]   trial;
   logic [tcpd_pkg::SUM_W-1:0]   trial_next;
   logic                         last_step;

   assign sum      = {1'b0, phase_ff} + tcpd_pkg::SUM_W'(tick_count);
   assign line_ext = {1'b0, line_len};
   assign diff     = sum - line_ext;
   assign len_zero = (line_len == '0);
   assign sum_lt   = (sum < line_ext);
   assign diff_lt  = (diff < line_ext);
   assign fast     = len_zero || sum_lt || diff_lt;

   assign trial      = {rem_ff, num_ff[tcpd_pkg::SUM_W-1]};
   assign trial_next = (trial >= line_ext) ? (trial - line_ext) : trial;
   assign last_step  = busy_ff && (cnt_ff == '0);

   always_comb begin
      phase_in = phase_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      if (busy_ff) begin
         num_in = {num_ff[tcpd_pkg::SUM_W-2:0], 1'b0};
         rem_in = trial_next[tcpd_pkg::PHASE_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (last_step) begin
            busy_in  = 1'b0;
            phase_in = trial_next[tcpd_pkg::PHASE_W-1:0];
         end
      end else if (start) begin
         priority if (len_zero) begin
            phase_in = '0;
         end else if (sum_lt) begin
            phase_in = sum[tcpd_pkg::PHASE_W-1:0];
         end else if (diff_lt) begin
            phase_in = diff[tcpd_pkg::PHASE_W-1:0];
         end else begin
            busy_in = 1'b1;
            num_in  = sum;
            rem_in  = '0;
            cnt_in  = tcpd_pkg::STEP_W'(tcpd_pkg::SUM_W - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign phase     = phase_ff;
   assign stat.fast = fast;
   assign stat.done = last_step;

endmodule

// ===== sv/text_card_port_decoder.sv =====
// ----------------------------------------------------------------------------
// Text card port decoder
// Bus-side model of an 80-column text card: video RAM, display registers,
// register select, status port and scan-line phase.
// ----------------------------------------------------------------------------
// After reset the card fills the whole video RAM with spaces and accepts no bus
// word meanwhile; register writes are taken at any time. Port writes, register
// and status reads, unmapped accesses, unused commands and ticks that find the
// card absent or need at most one subtraction push a result word at once.
// A video RAM read waits in the read state for the registered RAM read port.
// A tick that needs a full remainder waits in the tick state, one remainder bit per
// cycle in the line phase unit. Each word gives exactly one result word, and
// a two-entry output queue lets the next bus word in while a result waits.
module text_card_port_decoder #(
   parameter int RAM_SIZE  = tcpd_pkg::RAM_SIZE_DEF,
   parameter int REG_COUNT = tcpd_pkg::REG_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcpd_req_if.sink    req_chan,
   tcpd_rsp_if.source  rsp_chan,
   tcpd_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(RAM_SIZE);
   localparam int RW = $clog2(REG_COUNT);
   localparam int SEL_EXT_W = tcpd_pkg::SEL_W + 1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_TICK  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [AW-1:0]                   clr_addr_ff, clr_addr_in;
   logic                            present_ff, present_in;
   logic [tcpd_pkg::PHASE_W-1:0]    line_ff, line_in;
   logic [tcpd_pkg::PHASE_W-1:0]    blank_ff, blank_in;
   logic [tcpd_pkg::SEL_W-1:0]      select_ff, select_in;
   logic [tcpd_pkg::DATA_W-1:0]     crtc_ff [REG_COUNT];
   logic [tcpd_pkg::DATA_W-1:0]     crtc_in;
   logic                            crtc_we;
   tcpd_pkg::tcpd_rsp_word_type     head_ff, head_in;
   tcpd_pkg::tcpd_rsp_word_type     skid_ff, skid_in;
   logic                            head_v_ff, head_v_in;
   logic                            skid_v_ff, skid_v_in;

   logic                            accept;
   logic                            csr_wr;
   logic                            pop;
   logic                            push;
   tcpd_pkg::tcpd_rsp_word_type     push_word;
   logic [tcpd_pkg::DATA_W-1:0]     lo;
   logic                            is_ram;
   logic                            decodes;
   logic [10:0]                     ram_addr_full;
   logic [AW-1:0]                   ram_addr;
   logic [SEL_EXT_W-1:0]            sel_ext;
   logic [SEL_EXT_W-1:0]            sel_mod;
   logic [RW-1:0]                   crtc_idx;
   logic [tcpd_pkg::DATA_W-1:0]     status_byte;
   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_wr_addr;
   logic [tcpd_pkg::DATA_W-1:0]     ram_wr_data;
   logic                            ram_rd_en;
   logic [tcpd_pkg::DATA_W-1:0]     ram_rd_data;
   logic                            phase_start;
   logic [tcpd_pkg::PHASE_W-1:0]    phase;
   tcpd_pkg::tcpd_phase_stat_type   phase_stat;

   assign req_chan.ready = (state_ff == ST_IDLE) && !skid_v_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid && csr_chan.ready;

   assign lo      = req_chan.port_address[7:0];
   assign is_ram  = ((lo & tcpd_pkg::PORT_RAM_MASK) == tcpd_pkg::PORT_RAM_BASE);
   assign decodes = present_ff && (is_ram || (lo == tcpd_pkg::PORT_SELECT) ||
                    (lo == tcpd_pkg::PORT_DATA) || (lo == tcpd_pkg::PORT_STATUS));

   assign ram_addr_full = {req_chan.port_address[2:0], req_chan.port_address[15:8]};
   assign ram_addr      = ram_addr_full[AW-1:0];

   assign sel_ext  = {1'b0, select_ff};
   assign sel_mod  = (sel_ext >= SEL_EXT_W'(REG_COUNT)) ? (sel_ext - SEL_EXT_W'(REG_COUNT))
                                                        : sel_ext;
   assign crtc_idx = sel_mod[RW-1:0];

   assign status_byte = tcpd_pkg::STATUS_BASE |
                        ((phase < blank_ff) ? tcpd_pkg::STATUS_BLANK : '0);

   assign phase_start = accept && (req_chan.command == tcpd_pkg::CMD_TICK) && present_ff;

   tcpd_ram #(
      .WIDTH (tcpd_pkg::DATA_W),
      .DEPTH (RAM_SIZE)
   ) u_video_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   tcpd_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .start      (phase_start),
      .tick_count (req_chan.tick_count),
      .line_len   (line_ff),
      .phase      (phase),
      .stat       (phase_stat)
   );

   always_comb begin
      state_in            = state_ff;
      clr_addr_in         = clr_addr_ff;
      select_in           = select_ff;
      crtc_in             = req_chan.write_data;
      crtc_we             = 1'b0;
      push                = 1'b0;
      push_word.read_data = tcpd_pkg::NO_DATA;
      push_word.port_hit  = 1'b0;
      ram_wr_en           = 1'b0;
      ram_wr_addr         = ram_addr;
      ram_wr_data         = req_chan.write_data;
      ram_rd_en           = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = tcpd_pkg::FILL_BYTE;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(RAM_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.command)
                  tcpd_pkg::CMD_READ: begin
                     if (decodes && is_ram) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        push               = 1'b1;
                        push_word.port_hit = decodes;
                        priority if (decodes && (lo == tcpd_pkg::PORT_DATA)) begin
                           push_word.read_data = crtc_ff[crtc_idx];
                        end else if (decodes && (lo == tcpd_pkg::PORT_STATUS)) begin
                           push_word.read_data = status_byte;
                        end else begin
                           push_word.read_data = tcpd_pkg::NO_DATA;
                        end
                     end
                  end
                  tcpd_pkg::CMD_WRITE: begin
                     push               = 1'b1;
                     push_word.port_hit = decodes;
                     if (decodes) begin
                        priority if (is_ram) begin
                           ram_wr_en = 1'b1;
                        end else if (lo == tcpd_pkg::PORT_SELECT) begin
                           select_in = req_chan.write_data[tcpd_pkg::SEL_W-1:0];
                        end else if (lo == tcpd_pkg::PORT_DATA) begin
                           crtc_we = 1'b1;
                        end else begin
                           crtc_we = 1'b0;
                        end
                     end
                  end
                  tcpd_pkg::CMD_TICK: begin
                     if (present_ff && !phase_stat.fast) begin
                        state_in = ST_TICK;
                     end else begin
                        push = 1'b1;
                     end
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            push                = 1'b1;
            push_word.read_data = ram_rd_data;
            push_word.port_hit  = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_TICK: begin
            if (phase_stat.done) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      present_in = present_ff;
      line_in    = line_ff;
      blank_in   = blank_ff;
      if (csr_wr) begin
         unique case (csr_chan.index)
            tcpd_pkg::CSR_PRESENT: present_in = csr_chan.data[0];
            tcpd_pkg::CSR_LINE:    line_in    = csr_chan.data;
            tcpd_pkg::CSR_BLANK:   blank_in   = csr_chan.data;
            default:               present_in = present_ff;
         endcase
      end
   end

   assign pop = head_v_ff && rsp_chan.ready;

   always_comb begin
      head_in   = head_ff;
      skid_in   = skid_ff;
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      priority if (push && pop) begin
         if (skid_v_ff) begin
            head_in = skid_ff;
            skid_in = push_word;
         end else begin
            head_in = push_word;
         end
      end else if (push) begin
         if (!head_v_ff) begin
            head_in   = push_word;
            head_v_in = 1'b1;
         end else begin
            skid_in   = push_word;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         head_in   = skid_ff;
         head_v_in = skid_v_ff;
         skid_v_in = 1'b0;
      end else begin
         head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         present_ff  <= 1'b1;
         line_ff     <= tcpd_pkg::LINE_RESET;
         blank_ff    <= tcpd_pkg::BLANK_RESET;
         select_ff   <= '0;
         head_v_ff   <= 1'b0;
         skid_v_ff   <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            crtc_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         present_ff  <= present_in;
         line_ff     <= line_in;
         blank_ff    <= blank_in;
         select_ff   <= select_in;
         head_v_ff   <= head_v_in;
         skid_v_ff   <= skid_v_in;
         if (crtc_we) begin
            crtc_ff[crtc_idx] <= crtc_in;
         end
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid     = head_v_ff;
   assign rsp_chan.read_data = head_ff.read_data;
   assign rsp_chan.port_hit  = head_ff.port_hit;

   a_clear_blocks_bus: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_chan.ready)
      else $error("bus word taken during the RAM fill");

   a_ram_read_waits: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.command == tcpd_pkg::CMD_READ) && decodes && is_ram)
      |=> (state_ff == ST_READ))
      else $error("video RAM read did not enter the read wait state");

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> head_v_ff)
      else $error("output skid entry valid without a head entry");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_TICK)) |-> !ram_wr_en)
      else $error("video RAM written while a word is in progress");

endmodule

// ===== bench/text_card_port_decoder_test.sv =====
// ----------------------------------------------------------------------------
// Text card port decoder testbench
// Sends bus words (port reads, port writes, ticks) to the text card under a
// sequence of register settings. A scoreboard keeps its own copy of the card
// state, predicts the result word of every accepted bus word and compares it
// field by field with what the card returns. Except in the steady settings,
// both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module text_card_port_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [tcpd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int GAP_MAX      = 13;
   localparam int DRAIN_CYCLES = 32;
   localparam int WORDS_PER_SETTING = 105;

   class card_scoreboard;
      logic [tcpd_pkg::DATA_W-1:0] video_ram [tcpd_pkg::RAM_SIZE_DEF];
      logic [tcpd_pkg::DATA_W-1:0] crtc_regs [tcpd_pkg::REG_COUNT_DEF];
      logic [tcpd_pkg::SEL_W-1:0]  reg_select;
      int unsigned                 line_phase;
      logic                        present;
      int unsigned                 line_len;
      int unsigned                 blank_len;
      tcpd_pkg::tcpd_rsp_word_type expected_words[$];
      int                          failures;

      function new();
         foreach (video_ram[i]) video_ram[i] = tcpd_pkg::FILL_BYTE;
         foreach (crtc_regs[i]) crtc_regs[i] = '0;
         reg_select = '0;
         line_phase = 0;
         present    = 1'b1;
         line_len   = tcpd_pkg::LINE_RESET;
         blank_len  = tcpd_pkg::BLANK_RESET;
         failures   = 0;
      endfunction

      function void write_register(logic [tcpd_pkg::CSR_IDX_W-1:0] idx,
                                   logic [tcpd_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            tcpd_pkg::CSR_PRESENT: present = value[0];
            tcpd_pkg::CSR_LINE: line_len = value;
            tcpd_pkg::CSR_BLANK: blank_len = value;
            default: ;
         endcase
      endfunction

      function void note_bus_word(logic [tcpd_pkg::CMD_W-1:0] cmd,
                                  logic [tcpd_pkg::PORT_W-1:0] port,
                                  logic [tcpd_pkg::DATA_W-1:0] data,
                                  logic [tcpd_pkg::CNT_W-1:0] cnt);
         logic [tcpd_pkg::DATA_W-1:0] low;
         logic                        ram_hit;
         logic                        decoded;
         int unsigned                 ram_addr;
         tcpd_pkg::tcpd_rsp_word_type word;
         low      = port[7:0];
         ram_hit  = (low & tcpd_pkg::PORT_RAM_MASK) == tcpd_pkg::PORT_RAM_BASE;
         decoded  = present && (ram_hit || low == tcpd_pkg::PORT_SELECT ||
                                low == tcpd_pkg::PORT_DATA || low == tcpd_pkg::PORT_STATUS);
         ram_addr = {port[2:0], port[15:8]} % tcpd_pkg::RAM_SIZE_DEF;
         word.read_data = tcpd_pkg::NO_DATA;
         word.port_hit  = 1'b0;
         case (cmd)
            tcpd_pkg::CMD_READ: begin
               if (decoded) begin
                  word.port_hit = 1'b1;
                  if (ram_hit) begin
                     word.read_data = video_ram[ram_addr];
                  end else if (low == tcpd_pkg::PORT_DATA) begin
                     word.read_data = crtc_regs[reg_select % tcpd_pkg::REG_COUNT_DEF];
                  end else if (low == tcpd_pkg::PORT_STATUS) begin
                     word.read_data = tcpd_pkg::STATUS_BASE |
                                      ((line_phase < blank_len) ? tcpd_pkg::STATUS_BLANK
                                                                : 8'h00);
                  end
               end
            end
            tcpd_pkg::CMD_WRITE: begin
               if (decoded) begin
                  word.port_hit = 1'b1;
                  if (ram_hit) begin
                     video_ram[ram_addr] = data;
                  end else if (low == tcpd_pkg::PORT_SELECT) begin
                     reg_select = data[tcpd_pkg::SEL_W-1:0];
                  end else if (low == tcpd_pkg::PORT_DATA) begin
                     crtc_regs[reg_select % tcpd_pkg::REG_COUNT_DEF] = data;
                  end
               end
            end
            tcpd_pkg::CMD_TICK: begin
               if (present) begin
                  line_phase = (line_len == 0) ? 0 : (line_phase + cnt) % line_len;
               end
            end
            default: ;
         endcase
         expected_words = {expected_words, word};
      endfunction

      function void check_result(logic [tcpd_pkg::DATA_W-1:0] rd, logic hit);
         tcpd_pkg::tcpd_rsp_word_type word;
         if (expected_words.size() == 0) begin
            $error("result word with none expected: read_data %h port_hit %b", rd, hit);
            failures++;
            return;
         end
         word = expected_words.pop_front();
         if (rd !== word.read_data) begin
            $error("read_data: expected %h, actual %h", word.read_data, rd);
            failures++;
         end
         if (hit !== word.port_hit) begin
            $error("port_hit: expected %b, actual %b", word.port_hit, hit);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic steady;

   tcpd_req_if req_chan ();
   tcpd_rsp_if rsp_chan ();
   tcpd_csr_if csr_chan ();

   card_scoreboard card = new();

   text_card_port_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            card.write_register(csr_chan.index, csr_chan.data);
         end
         if (req_chan.valid && req_chan.ready) begin
            card.note_bus_word(req_chan.command, req_chan.port_address,
                               req_chan.write_data, req_chan.tick_count);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            card.check_result(rsp_chan.read_data, rsp_chan.port_hit);
         end
      end
   end

   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   task automatic send_bus_word(input logic [tcpd_pkg::CMD_W-1:0] cmd,
                                input logic [tcpd_pkg::PORT_W-1:0] port,
                                input logic [tcpd_pkg::DATA_W-1:0] data,
                                input logic [tcpd_pkg::CNT_W-1:0] cnt);
      int gap;
      gap = steady ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.port_address <= port;
      req_chan.write_data   <= data;
      req_chan.tick_count   <= cnt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (card.expected_words.size() != 0);
   endtask

   task automatic set_card(input logic present,
                           input logic [tcpd_pkg::CSR_DATA_W-1:0] line_len,
                           input logic [tcpd_pkg::CSR_DATA_W-1:0] blank_len);
      logic [tcpd_pkg::CSR_DATA_W-1:0] values [3];
      logic [tcpd_pkg::CSR_IDX_W-1:0]  indexes [3];
      values[0]  = {{(tcpd_pkg::CSR_DATA_W-1){1'b0}}, present};
      values[1]  = line_len;
      values[2]  = blank_len;
      indexes[0] = tcpd_pkg::CSR_PRESENT;
      indexes[1] = tcpd_pkg::CSR_LINE;
      indexes[2] = tcpd_pkg::CSR_BLANK;
      for (int i = 0; i < 3; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= indexes[i];
         csr_chan.data  <= values[i];
         @(posedge clock);
         while (!csr_chan.ready) @(posedge clock);
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_random_words(input int count);
      logic [tcpd_pkg::CMD_W-1:0]  cmd;
      logic [tcpd_pkg::PORT_W-1:0] port;
      logic [tcpd_pkg::DATA_W-1:0] data;
      logic [tcpd_pkg::CNT_W-1:0]  cnt;
      logic [7:0]                  hot_rows [4];
      int                          pick;
      foreach (hot_rows[i]) hot_rows[i] = 8'($urandom);
      for (int n = 0; n < count; n++) begin
         port = tcpd_pkg::PORT_W'($urandom);
         data = tcpd_pkg::DATA_W'($urandom);
         cnt  = tcpd_pkg::CNT_W'($urandom);
         cmd  = $urandom_range(0, 1) ? tcpd_pkg::CMD_WRITE : tcpd_pkg::CMD_READ;
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // Video RAM traffic mostly lands on a few rows so reads find written bytes.
            port[7:0] = tcpd_pkg::PORT_RAM_BASE | 8'($urandom_range(0, 7));
            if ($urandom_range(0, 3) != 0) port[15:8] = hot_rows[$urandom_range(0, 3)];
         end else if (pick < 42) begin
            port[7:0] = tcpd_pkg::PORT_SELECT;
            cmd = ($urandom_range(0, 5) == 0) ? tcpd_pkg::CMD_READ : tcpd_pkg::CMD_WRITE;
         end else if (pick < 58) begin
            port[7:0] = tcpd_pkg::PORT_DATA;
         end else if (pick < 66) begin
            port[7:0] = tcpd_pkg::PORT_STATUS;
            cmd = ($urandom_range(0, 7) == 0) ? tcpd_pkg::CMD_WRITE : tcpd_pkg::CMD_READ;
         end else if (pick < 86) begin
            cmd = tcpd_pkg::CMD_TICK;
         end else if (pick >= 96) begin
            cmd = tcpd_pkg::CMD_W'($urandom);
         end
         send_bus_word(cmd, port, data, cnt);
      end
   endtask

   initial begin
      logic                            present;
      logic [tcpd_pkg::CSR_DATA_W-1:0] line_len;
      logic [tcpd_pkg::CSR_DATA_W-1:0] blank_len;
      steady                <= 1'b0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= tcpd_pkg::CMD_READ;
      req_chan.port_address <= '0;
      req_chan.write_data   <= '0;
      req_chan.tick_count   <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= tcpd_pkg::CSR_PRESENT;
      csr_chan.data         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_bus_word(tcpd_pkg::CMD_WRITE, 16'h0040, 8'h00, 8'h00);
      send_bus_word(tcpd_pkg::CMD_WRITE, 16'hff47, 8'hff, 8'hff);
      send_bus_word(tcpd_pkg::CMD_READ, 16'hff47, 8'h00, 8'hff);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h1243, 8'hff, 8'h00);
      send_bus_word(tcpd_pkg::CMD_WRITE, 16'h0048, 8'hff, 8'h00);
      send_bus_word(tcpd_pkg::CMD_WRITE, 16'hff49, 8'ha5, 8'hff);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h0049, 8'h00, 8'h00);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h0048, 8'h00, 8'h00);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h004c, 8'h00, 8'h00);
      send_bus_word(tcpd_pkg::CMD_WRITE, 16'h004c, 8'hff, 8'h00);
      send_bus_word(tcpd_pkg::CMD_READ, 16'hff4d, 8'h00, 8'h00);
      send_bus_word(CMD_UNUSED, 16'h0040, 8'h5a, 8'hff);
      wait_drained();

      // With the card absent nothing decodes and the write and tick are lost.
      set_card(1'b0, tcpd_pkg::LINE_RESET, tcpd_pkg::BLANK_RESET);
      send_bus_word(tcpd_pkg::CMD_WRITE, 16'h0040, 8'h55, 8'h00);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h0040, 8'h00, 8'h00);
      send_bus_word(tcpd_pkg::CMD_TICK, 16'h0000, 8'h00, 8'hff);
      wait_drained();

      set_card(1'b1, 12'd4095, 12'd4095);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h0040, 8'h00, 8'h00);
      repeat (5) send_bus_word(tcpd_pkg::CMD_TICK, 16'hffff, 8'hff, 8'hff);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h004c, 8'h00, 8'h00);
      wait_drained();

      // The phase now sits past the shortened line end.
      set_card(1'b1, tcpd_pkg::LINE_RESET, 12'd0);
      send_bus_word(tcpd_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h01);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h004c, 8'h00, 8'h00);
      wait_drained();

      set_card(1'b1, 12'd0, 12'd4095);
      send_bus_word(tcpd_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h80);
      send_bus_word(tcpd_pkg::CMD_READ, 16'h004c, 8'h00, 8'h00);
      wait_drained();

      for (int p = 0; p < 12; p++) begin
         steady    <= (p % 4 == 3);
         present   = (p != 6);
         line_len  = (p == 0) ? 12'd256 : (p == 1) ? 12'd4095 :
                     tcpd_pkg::CSR_DATA_W'($urandom_range(256, 4095));
         blank_len = (p == 2) ? 12'd0 : (p == 3) ? 12'd4095 :
                     tcpd_pkg::CSR_DATA_W'($urandom_range(0, line_len));
         set_card(present, line_len, blank_len);
         run_random_words(present ? WORDS_PER_SETTING : 30);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (card.expected_words.size() != 0) begin
         $error("%0d result words never arrived", card.expected_words.size());
         card.failures++;
      end
      if (card.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
